@@ hdl/bba_pkg.sv @@
// Shared types and constants for the buddy block allocator.
package bba_pkg;

  // Heap geometry. The heap is in kilobytes, and node 1 is the whole heap.
  localparam int TOTAL_SIZE = 1024;
  localparam int MIN_SIZE   = 16;
  localparam int TREE_DEPTH = $clog2(TOTAL_SIZE / MIN_SIZE);
  localparam int NODE_COUNT = 2 * (TOTAL_SIZE / MIN_SIZE);
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int LVL_W      = $clog2(TREE_DEPTH + 1);

  // Fixed field widths of the command and result words.
  localparam int REQ_W   = 16;
  localparam int BLOCK_W = 7;

  // Commands.
  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_LARGE = 2'd1,
    STAT_NO_SPACE  = 2'd2,
    STAT_NOT_USED  = 2'd3
  } status_e;

  // State of one tree node.
  typedef enum logic [1:0] {
    NODE_ABSENT = 2'd0,
    NODE_FREE   = 2'd1,
    NODE_SPLIT  = 2'd2,
    NODE_USED   = 2'd3
  } node_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_EVAL,
    S_A_BACK,
    S_A_SPLIT,
    S_A_RSIB,
    S_F_RD,
    S_F_EVAL,
    S_F_BUD_RD,
    S_F_BUD_EVAL,
    S_F_CLR
  } fsm_e;

  // Command word.
  typedef struct packed {
    logic               command;
    logic [REQ_W-1:0]   request_size;
    logic [BLOCK_W-1:0] block_to_free;
  } cmd_t;

  // Result word.
  typedef struct packed {
    logic [BLOCK_W-1:0] block_number;
    status_e            status;
  } res_t;

  // Access request to the node store.
  typedef struct packed {
    logic              re;
    logic [NODE_W-1:0] raddr;
    logic              we;
    logic [NODE_W-1:0] waddr;
    node_e             wdata;
  } mem_req_t;

  // Tree level (0 is the root) of the smallest block that holds the request.
  // The request is assumed to be no larger than the heap.
  function automatic logic [LVL_W-1:0] want_level(logic [REQ_W-1:0] req);
    logic [LVL_W-1:0] lvl;
    lvl = '0;
    for (int i = 0; i <= TREE_DEPTH; i++) begin
      if (32'(req) <= (TOTAL_SIZE >> i)) begin
        lvl = LVL_W'(i);
      end
    end
    return lvl;
  endfunction

endpackage

@@ hdl/bba_node_store.sv @@
// Node state memory: one write and one registered read per cycle.
// Entries that were never written since reset read as the reset tree
// (root free, every other node absent), tracked by one valid bit per entry.
module bba_node_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bba_pkg::mem_req_t req_i,
  output bba_pkg::node_e    rd_data_o
);

  bba_pkg::node_e                   mem_q [bba_pkg::NODE_COUNT];
  logic [bba_pkg::NODE_COUNT-1:0]   valid_q;
  bba_pkg::node_e                   rdata_q;
  logic                             rd_valid_q;
  logic                             rd_root_q;

  // Valid bits: cleared by reset, set on the first write of an entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  // Storage array and registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q    <= mem_q[req_i.raddr];
      rd_valid_q <= valid_q[req_i.raddr];
      rd_root_q  <= (req_i.raddr == bba_pkg::NODE_W'(1));
    end
  end

  // Entries not yet written give their reset value.
  always_comb begin
    if (rd_valid_q) begin
      rd_data_o = rdata_q;
    end else if (rd_root_q) begin
      rd_data_o = bba_pkg::NODE_FREE;
    end else begin
      rd_data_o = bba_pkg::NODE_ABSENT;
    end
  end

endmodule

@@ hdl/buddy_block_allocator_unit.sv @@
// Channel   | Ports                      | Handshake
// ----------+----------------------------+------------------------------------
// command   | start, busy, cmd_i         | taken when start is high, busy low
// result    | done_o, result_o           | one cycle, marked by done_o
//
// One command word is worked at a time; busy stays high until its result is out,
// and the receiver cannot stall. Too large requests and frees of block 0 are answered
// from idle, without raising busy. Allocate walks the tree depth-first, stepping back
// past used or absent nodes and splitting a larger free block down to the wanted level.
// Free checks that the block is in use, then merges it with free buddies up the tree.
// After reset the tree is a single free root; there is no clearing pass.
module buddy_block_allocator_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  bba_pkg::cmd_t   cmd_i,
  output logic            done_o,
  output bba_pkg::res_t   result_o
);

  localparam int NW = bba_pkg::NODE_W;
  localparam int LW = bba_pkg::LVL_W;

  bba_pkg::fsm_e     state_q, state_d;
  logic [NW-1:0]     node_q, node_d;
  logic [LW-1:0]     depth_q, depth_d;
  logic [LW-1:0]     lvl_q, lvl_d;
  logic              done_q, done_d;
  bba_pkg::res_t     res_q, res_d;
  bba_pkg::mem_req_t mem_req;
  bba_pkg::node_e    rd_data;
  logic [NW-1:0]     left_child;
  logic [NW-1:0]     right_child;
  logic [NW-1:0]     buddy;
  logic              at_level;

  // Node state memory.
  bba_node_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  // Tree navigation helpers.
  assign left_child  = {node_q[NW-2:0], 1'b0};
  assign right_child = {node_q[NW-2:0], 1'b1};
  assign buddy       = node_q ^ NW'(1);
  assign at_level    = (depth_q == lvl_q);

  // Next state, memory accesses and result.
  always_comb begin
    state_d         = state_q;
    node_d          = node_q;
    depth_d         = depth_q;
    lvl_d           = lvl_q;
    done_d          = 1'b0;
    res_d           = res_q;
    mem_req.re      = 1'b0;
    mem_req.raddr   = node_q;
    mem_req.we      = 1'b0;
    mem_req.waddr   = node_q;
    mem_req.wdata   = bba_pkg::NODE_ABSENT;

    unique case (state_q)
      bba_pkg::S_IDLE: begin
        if (start) begin
          if (cmd_i.command == bba_pkg::CMD_ALLOC) begin
            if (32'(cmd_i.request_size) > bba_pkg::TOTAL_SIZE) begin
              done_d             = 1'b1;
              res_d.block_number = '0;
              res_d.status       = bba_pkg::STAT_TOO_LARGE;
            end else begin
              lvl_d   = bba_pkg::want_level(cmd_i.request_size);
              node_d  = NW'(1);
              depth_d = '0;
              state_d = bba_pkg::S_A_RD;
            end
          end else begin
            if (cmd_i.block_to_free == '0) begin
              done_d             = 1'b1;
              res_d.block_number = '0;
              res_d.status       = bba_pkg::STAT_NOT_USED;
            end else begin
              node_d  = NW'(cmd_i.block_to_free);
              state_d = bba_pkg::S_F_RD;
            end
          end
        end
      end

      // Allocate: read the current node of the depth-first walk.
      bba_pkg::S_A_RD: begin
        mem_req.re = 1'b1;
        state_d    = bba_pkg::S_A_EVAL;
      end

      bba_pkg::S_A_EVAL: begin
        if (rd_data == bba_pkg::NODE_ABSENT || rd_data == bba_pkg::NODE_USED) begin
          state_d = bba_pkg::S_A_BACK;
        end else if (at_level) begin
          if (rd_data == bba_pkg::NODE_FREE) begin
            mem_req.we         = 1'b1;
            mem_req.wdata      = bba_pkg::NODE_USED;
            done_d             = 1'b1;
            res_d.block_number = bba_pkg::BLOCK_W'(node_q);
            res_d.status       = bba_pkg::STAT_OK;
            state_d            = bba_pkg::S_IDLE;
          end else begin
            state_d = bba_pkg::S_A_BACK;
          end
        end else if (rd_data == bba_pkg::NODE_SPLIT) begin
          node_d  = left_child;
          depth_d = depth_q + LW'(1);
          state_d = bba_pkg::S_A_RD;
        end else begin
          state_d = bba_pkg::S_A_SPLIT;
        end
      end

      // Step back: to the right sibling, or up past finished right children.
      bba_pkg::S_A_BACK: begin
        if (node_q == NW'(1)) begin
          done_d             = 1'b1;
          res_d.block_number = '0;
          res_d.status       = bba_pkg::STAT_NO_SPACE;
          state_d            = bba_pkg::S_IDLE;
        end else if (!node_q[0]) begin
          node_d  = node_q + NW'(1);
          state_d = bba_pkg::S_A_RD;
        end else begin
          node_d  = node_q >> 1;
          depth_d = depth_q - LW'(1);
        end
      end

      // Free block found above the wanted level: split down its left edge.
      bba_pkg::S_A_SPLIT: begin
        mem_req.we = 1'b1;
        if (at_level) begin
          mem_req.wdata      = bba_pkg::NODE_USED;
          done_d             = 1'b1;
          res_d.block_number = bba_pkg::BLOCK_W'(node_q);
          res_d.status       = bba_pkg::STAT_OK;
          state_d            = bba_pkg::S_IDLE;
        end else begin
          mem_req.wdata = bba_pkg::NODE_SPLIT;
          state_d       = bba_pkg::S_A_RSIB;
        end
      end

      bba_pkg::S_A_RSIB: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = right_child;
        mem_req.wdata = bba_pkg::NODE_FREE;
        node_d        = left_child;
        depth_d       = depth_q + LW'(1);
        state_d       = bba_pkg::S_A_SPLIT;
      end

      // Free: check that the block is in use.
      bba_pkg::S_F_RD: begin
        mem_req.re = 1'b1;
        state_d    = bba_pkg::S_F_EVAL;
      end

      bba_pkg::S_F_EVAL: begin
        if (rd_data != bba_pkg::NODE_USED) begin
          done_d             = 1'b1;
          res_d.block_number = '0;
          res_d.status       = bba_pkg::STAT_NOT_USED;
          state_d            = bba_pkg::S_IDLE;
        end else begin
          state_d = bba_pkg::S_F_BUD_RD;
        end
      end

      // Merge loop: look at the buddy of the current block.
      bba_pkg::S_F_BUD_RD: begin
        if (node_q == NW'(1)) begin
          mem_req.we         = 1'b1;
          mem_req.wdata      = bba_pkg::NODE_FREE;
          done_d             = 1'b1;
          res_d.block_number = '0;
          res_d.status       = bba_pkg::STAT_OK;
          state_d            = bba_pkg::S_IDLE;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = buddy;
          state_d       = bba_pkg::S_F_BUD_EVAL;
        end
      end

      bba_pkg::S_F_BUD_EVAL: begin
        mem_req.we = 1'b1;
        if (rd_data == bba_pkg::NODE_FREE) begin
          mem_req.waddr = buddy;
          mem_req.wdata = bba_pkg::NODE_ABSENT;
          state_d       = bba_pkg::S_F_CLR;
        end else begin
          mem_req.wdata      = bba_pkg::NODE_FREE;
          done_d             = 1'b1;
          res_d.block_number = '0;
          res_d.status       = bba_pkg::STAT_OK;
          state_d            = bba_pkg::S_IDLE;
        end
      end

      // Both halves gone; continue with the parent.
      bba_pkg::S_F_CLR: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = bba_pkg::NODE_ABSENT;
        node_d        = node_q >> 1;
        state_d       = bba_pkg::S_F_BUD_RD;
      end

      default: begin
        state_d = bba_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bba_pkg::S_IDLE;
      node_q  <= '0;
      depth_q <= '0;
      lvl_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      node_q  <= node_d;
      depth_q <= depth_d;
      lvl_q   <= lvl_d;
      done_q  <= done_d;
    end
  end

  // Result word register.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy     = (state_q != bba_pkg::S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

@@ tb/tb_buddy_block_allocator_unit.sv @@
`timescale 1ns / 1ps

module tb_buddy_block_allocator_unit;

  localparam int          NODES       = bba_pkg::NODE_COUNT;
  localparam int          PHASES      = 3;
  localparam int          PHASE_WORDS = 517;
  localparam int unsigned CYCLE_LIMIT = 2_500_000;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           start;
  logic           busy;
  bba_pkg::cmd_t  cmd_i;
  logic           done_o;
  bba_pkg::res_t  result_o;

  // Two copies of the heap tree: index 0 plans the stimulus, index 1 predicts
  // the results of the words that the block actually accepts.
  bba_pkg::node_e heap_tree [2][NODES];

  bba_pkg::cmd_t pend_q [$];
  bba_pkg::res_t expected_q [$];
  int unsigned   queued_cnt = 0;
  int unsigned   acc_cnt = 0;
  int unsigned   alloc_cnt = 0;
  int unsigned   free_cnt = 0;
  int unsigned   status_cnt [4] = '{0, 0, 0, 0};
  int unsigned   mismatch_cnt = 0;
  int unsigned   cycle_cnt = 0;
  int unsigned   idle_pct = 0;
  int unsigned   gap_left = 0;
  logic          accepted_last = 1'b0;
  bba_pkg::res_t exp_r;

  buddy_block_allocator_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_i    (cmd_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always #1 clk_i = ~clk_i;

  // Tree after reset: a single free root.
  function automatic void heap_clear(input int m);
    for (int n = 0; n < NODES; n++) begin
      heap_tree[m][n] = bba_pkg::NODE_ABSENT;
    end
    heap_tree[m][1] = bba_pkg::NODE_FREE;
  endfunction

  // Left-first search for a free block of exactly the wanted size, splitting
  // larger free blocks on the way down. Returns 0 when nothing fits.
  function automatic int unsigned heap_take(input int m, input int unsigned n,
                                            input int unsigned blk_size,
                                            input int unsigned want);
    int unsigned got;
    if (n == 0 || n >= NODES) return 0;
    if (heap_tree[m][n] == bba_pkg::NODE_USED ||
        heap_tree[m][n] == bba_pkg::NODE_ABSENT) return 0;
    if (blk_size == want) begin
      if (heap_tree[m][n] == bba_pkg::NODE_FREE) begin
        heap_tree[m][n] = bba_pkg::NODE_USED;
        return n;
      end
      return 0;
    end
    if (blk_size < want || 2 * n + 1 >= NODES) return 0;
    if (heap_tree[m][n] == bba_pkg::NODE_FREE) begin
      heap_tree[m][n]         = bba_pkg::NODE_SPLIT;
      heap_tree[m][2 * n]     = bba_pkg::NODE_FREE;
      heap_tree[m][2 * n + 1] = bba_pkg::NODE_FREE;
    end
    got = heap_take(m, 2 * n, blk_size / 2, want);
    if (got == 0) begin
      got = heap_take(m, 2 * n + 1, blk_size / 2, want);
    end
    return got;
  endfunction

  // Applies one command word to a tree copy and returns its result word.
  function automatic bba_pkg::res_t heap_apply(input int m, input bba_pkg::cmd_t c);
    bba_pkg::res_t r;
    int unsigned   want;
    int unsigned   got;
    int unsigned   n;
    r.block_number = '0;
    r.status       = bba_pkg::STAT_OK;
    if (c.command == bba_pkg::CMD_ALLOC) begin
      if (int'(c.request_size) > bba_pkg::TOTAL_SIZE) begin
        r.status = bba_pkg::STAT_TOO_LARGE;
      end else begin
        want = bba_pkg::MIN_SIZE;
        while (want < c.request_size) want = want * 2;
        got = heap_take(m, 1, bba_pkg::TOTAL_SIZE, want);
        if (got == 0) begin
          r.status = bba_pkg::STAT_NO_SPACE;
        end else begin
          r.block_number = bba_pkg::BLOCK_W'(got);
        end
      end
    end else begin
      n = c.block_to_free;
      if (n == 0 || n >= NODES || heap_tree[m][n] != bba_pkg::NODE_USED) begin
        r.status = bba_pkg::STAT_NOT_USED;
      end else begin
        // Release, then merge free buddy pairs up the tree.
        heap_tree[m][n] = bba_pkg::NODE_FREE;
        while (n > 1 && heap_tree[m][n ^ 1] == bba_pkg::NODE_FREE) begin
          heap_tree[m][n]     = bba_pkg::NODE_ABSENT;
          heap_tree[m][n ^ 1] = bba_pkg::NODE_ABSENT;
          n = n >> 1;
          heap_tree[m][n] = bba_pkg::NODE_FREE;
        end
      end
    end
    return r;
  endfunction

  // Queues one command word and advances the planning tree with it.
  function automatic bba_pkg::res_t queue_item(input bba_pkg::cmd_e op,
                                               input int unsigned req,
                                               input int unsigned blk);
    bba_pkg::cmd_t c;
    c.command       = op;
    c.request_size  = bba_pkg::REQ_W'(req);
    c.block_to_free = bba_pkg::BLOCK_W'(blk);
    pend_q.push_back(c);
    queued_cnt++;
    return heap_apply(0, c);
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_cnt++;
    $display("[%0t] ERROR: %s", $realtime, what);
  endtask

  // Waits until every queued word is accepted and every result has come.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pend_q.size() != 0 || acc_cnt != queued_cnt || expected_q.size() != 0);
  endtask

  // Driver: holds a word until it is taken, then moves on or idles a while.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start    <= 1'b0;
      cmd_i    <= '0;
      gap_left <= 0;
    end else if (start && !accepted_last) begin
      start <= 1'b1;
    end else if (gap_left != 0) begin
      start    <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pend_q.size() == 0) begin
      start <= 1'b0;
    end else if ($urandom_range(99) < idle_pct) begin
      start    <= 1'b0;
      gap_left <= $urandom_range(5);
    end else begin
      start <= 1'b1;
      cmd_i <= pend_q.pop_front();
    end
  end

  // Monitor: checks each result word, then predicts for each accepted word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (expected_q.size() == 0) begin
          flag_mismatch($sformatf("result word with none expected: block %0d status %0d",
                                  result_o.block_number, result_o.status));
        end else begin
          exp_r = expected_q.pop_front();
          status_cnt[exp_r.status]++;
          if (result_o.block_number !== exp_r.block_number) begin
            flag_mismatch($sformatf("block_number %0d, expected %0d",
                                    result_o.block_number, exp_r.block_number));
          end
          if (result_o.status !== exp_r.status) begin
            flag_mismatch($sformatf("status %0d, expected %s",
                                    result_o.status, exp_r.status.name()));
          end
        end
      end
      accepted_last <= start && !busy;
      if (start && !busy) begin
        expected_q.push_back(heap_apply(1, cmd_i));
        acc_cnt <= acc_cnt + 1;
        if (cmd_i.command == bba_pkg::CMD_ALLOC) alloc_cnt <= alloc_cnt + 1;
        else free_cnt <= free_cnt + 1;
      end
    end else begin
      accepted_last <= 1'b0;
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned   phase_idle [PHASES];
    bba_pkg::res_t r;
    int unsigned   a, b, c16, d, half_lo, half_hi, b64, b65;
    int unsigned   roll, lvl, sz, req, pick;
    int unsigned   live [$];

    phase_idle = '{0, 46, 24};
    rst_ni = 1'b0;
    heap_clear(0);
    heap_clear(1);
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed words: rounding of tiny and exact sizes, the whole heap,
    // oversize requests, invalid frees and merging back to the root.
    r = queue_item(bba_pkg::CMD_ALLOC, 0, 0);       a   = r.block_number;
    r = queue_item(bba_pkg::CMD_ALLOC, 1, 127);     b   = r.block_number;
    r = queue_item(bba_pkg::CMD_ALLOC, bba_pkg::MIN_SIZE, 0); c16 = r.block_number;
    r = queue_item(bba_pkg::CMD_ALLOC, bba_pkg::MIN_SIZE + 1, 0); d = r.block_number;
    void'(queue_item(bba_pkg::CMD_ALLOC, bba_pkg::TOTAL_SIZE, 0));
    void'(queue_item(bba_pkg::CMD_ALLOC, bba_pkg::TOTAL_SIZE + 1, 0));
    void'(queue_item(bba_pkg::CMD_ALLOC, 16'hFFFF, 127));
    void'(queue_item(bba_pkg::CMD_FREE, 16'hFFFF, 0));
    void'(queue_item(bba_pkg::CMD_FREE, 0, 127));
    void'(queue_item(bba_pkg::CMD_FREE, 0, 1));
    void'(queue_item(bba_pkg::CMD_FREE, 0, a));
    void'(queue_item(bba_pkg::CMD_FREE, 0, a));
    void'(queue_item(bba_pkg::CMD_FREE, 0, b));
    void'(queue_item(bba_pkg::CMD_FREE, 0, c16));
    void'(queue_item(bba_pkg::CMD_FREE, 0, d));
    void'(queue_item(bba_pkg::CMD_ALLOC, bba_pkg::TOTAL_SIZE, 0));
    void'(queue_item(bba_pkg::CMD_ALLOC, 1, 0));
    void'(queue_item(bba_pkg::CMD_FREE, 0, 1));
    r = queue_item(bba_pkg::CMD_ALLOC, bba_pkg::TOTAL_SIZE / 2, 0); half_lo = r.block_number;
    r = queue_item(bba_pkg::CMD_ALLOC, bba_pkg::TOTAL_SIZE / 2, 0); half_hi = r.block_number;
    void'(queue_item(bba_pkg::CMD_ALLOC, bba_pkg::MIN_SIZE, 0));
    void'(queue_item(bba_pkg::CMD_FREE, 0, half_hi));
    void'(queue_item(bba_pkg::CMD_FREE, 0, half_lo));
    r = queue_item(bba_pkg::CMD_ALLOC, 64, 0); b64 = r.block_number;
    r = queue_item(bba_pkg::CMD_ALLOC, 65, 0); b65 = r.block_number;
    void'(queue_item(bba_pkg::CMD_FREE, 0, b64));
    void'(queue_item(bba_pkg::CMD_FREE, 0, b65));

    // Random words, mostly frees of live blocks and well-formed allocations.
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        wait_drained();
        @(posedge clk_i);
      end
      idle_pct = phase_idle[ph];
      for (int i = 0; i < PHASE_WORDS; i++) begin
        live.delete();
        for (int n = 1; n < NODES; n++) begin
          if (heap_tree[0][n] == bba_pkg::NODE_USED) live.push_back(n);
        end
        roll = $urandom_range(99);
        if (roll < 5) begin
          void'(queue_item(bba_pkg::CMD_ALLOC,
                           $urandom_range(16'hFFFF, bba_pkg::TOTAL_SIZE + 1), $urandom));
        end else if (roll < 10) begin
          void'(queue_item(bba_pkg::CMD_FREE, $urandom, $urandom_range(NODES - 1)));
        end else if (live.size() != 0 && roll < 10 + (live.size() > 8 ? 50 : 30)) begin
          pick = live[$urandom_range(live.size() - 1)];
          void'(queue_item(bba_pkg::CMD_FREE, $urandom, pick));
        end else begin
          // Favor small blocks so the heap fragments and fills up.
          if ($urandom_range(3) == 0) lvl = $urandom_range(bba_pkg::TREE_DEPTH);
          else lvl = $urandom_range(bba_pkg::TREE_DEPTH, bba_pkg::TREE_DEPTH / 2);
          sz = bba_pkg::TOTAL_SIZE >> lvl;
          if (lvl == bba_pkg::TREE_DEPTH) req = $urandom_range(bba_pkg::MIN_SIZE);
          else req = $urandom_range(sz, sz / 2 + 1);
          void'(queue_item(bba_pkg::CMD_ALLOC, req, $urandom));
        end
      end
    end

    wait_drained();
    repeat (40) @(negedge clk_i);
    $display("Accepted %0d allocate and %0d free words over %0d idling phases.",
             alloc_cnt, free_cnt, PHASES);
    $display("Results: %0d ok, %0d too large, %0d no space, %0d not in use.",
             status_cnt[bba_pkg::STAT_OK], status_cnt[bba_pkg::STAT_TOO_LARGE],
             status_cnt[bba_pkg::STAT_NO_SPACE], status_cnt[bba_pkg::STAT_NOT_USED]);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
